// ===== hdl/cdw_pkg.sv =====
`default_nettype none

package cdw_pkg;

    localparam int unsigned MASK_W     = 10;
    localparam int unsigned CP_IDX_W   = 4;
    localparam int unsigned DL_REG_W   = 60;
    localparam int unsigned PER_REG    = 5;
    localparam int unsigned CFG_IDX_W  = 2;

    localparam logic [MASK_W-1:0]   START_MASK_RST  = 10'd17;
    localparam logic [MASK_W-1:0]   END_MASK_RST    = 10'd136;
    localparam logic [DL_REG_W-1:0] DL_LOW_RST      = 60'd284289743423161330;
    localparam logic [DL_REG_W-1:0] DL_HIGH_RST     = 60'd4137060;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_MASK = 2'd0,
        REG_END_MASK   = 2'd1,
        REG_DL_LOW     = 2'd2,
        REG_DL_HIGH    = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic tick;
        logic hit;
        logic start;
        logic stop;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/cdw_ifs.sv =====
`default_nettype none

interface cdw_item_if;
    logic                           valid;
    logic                           ready;
    logic                           func;
    logic [cdw_pkg::CP_IDX_W-1:0]   cp_index;

    modport source (output valid, output func, output cp_index, input ready);
    modport sink   (input valid, input func, input cp_index, output ready);
endinterface

interface cdw_result_if;
    logic                           valid;
    logic                           ready;
    logic [cdw_pkg::MASK_W-1:0]     expired_mask;
    logic                           any_expired;

    modport source (output valid, output expired_mask, output any_expired, input ready);
    modport sink   (input valid, input expired_mask, input any_expired, output ready);
endinterface

interface cdw_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [cdw_pkg::CFG_IDX_W-1:0]  index;
    logic [cdw_pkg::DL_REG_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/cdw_cfg.sv =====
`default_nettype none

module cdw_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    cdw_cfg_if.sink                            cfg,
    output logic [cdw_pkg::MASK_W-1:0]         start_mask,
    output logic [cdw_pkg::MASK_W-1:0]         end_mask,
    output logic [cdw_pkg::DL_REG_W-1:0]       deadlines_low,
    output logic [cdw_pkg::DL_REG_W-1:0]       deadlines_high
);
    import cdw_pkg::*;

    logic [MASK_W-1:0]   start_reg;
    logic [MASK_W-1:0]   end_reg;
    logic [DL_REG_W-1:0] dl_low_reg;
    logic [DL_REG_W-1:0] dl_high_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg   <= START_MASK_RST;
            end_reg     <= END_MASK_RST;
            dl_low_reg  <= DL_LOW_RST;
            dl_high_reg <= DL_HIGH_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_START_MASK: start_reg   <= cfg.data[MASK_W-1:0];
                REG_END_MASK:   end_reg     <= cfg.data[MASK_W-1:0];
                REG_DL_LOW:     dl_low_reg  <= cfg.data;
                REG_DL_HIGH:    dl_high_reg <= cfg.data;
            endcase
        end
    end

    assign start_mask     = start_reg;
    assign end_mask       = end_reg;
    assign deadlines_low  = dl_low_reg;
    assign deadlines_high = dl_high_reg;

endmodule

`default_nettype wire

// ===== hdl/cdw_cell.sv =====
`default_nettype none

module cdw_cell #(
    parameter int unsigned DEADLINE_WIDTH = 12
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire cdw_pkg::cell_ctrl_t        ctrl,
    input  wire logic [DEADLINE_WIDTH-1:0]  deadline,
    input  wire logic                       disarm_in,
    output logic                            disarm_out,
    output logic                            expired
);
    import cdw_pkg::*;

    logic                      armed_reg;
    logic                      armed_next;
    logic [DEADLINE_WIDTH-1:0] count_reg;
    logic [DEADLINE_WIDTH-1:0] count_next;
    logic                      load;
    logic                      decr;

    // end wins over start; a plain checkpoint both arms and releases its predecessor
    assign load       = ctrl.hit & ~ctrl.stop;
    assign disarm_out = ctrl.hit & (ctrl.stop | ~ctrl.start);
    assign decr       = ctrl.tick & armed_reg & (count_reg != '0);
    assign expired    = decr & (count_reg == DEADLINE_WIDTH'(1));

    always_comb
    begin
        armed_next = armed_reg;
        count_next = count_reg;
        priority if (load)
        begin
            armed_next = 1'b1;
            count_next = deadline;
        end
        else if (disarm_in)
        begin
            armed_next = 1'b0;
        end
        else if (decr)
        begin
            count_next = count_reg - DEADLINE_WIDTH'(1);
            if (expired)
            begin
                armed_next = 1'b0;
            end
        end
        else
        begin
            armed_next = armed_reg;
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg <= 1'b0;
        end
        else
        begin
            armed_reg <= armed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg <= count_next;
    end

endmodule

`default_nettype wire

// ===== hdl/checkpoint_deadline_watchdog_core.sv =====
`default_nettype none

// Channel   Role     Payload                          Transfer when
// item      sink     func, cp_index                   valid && ready
// result    source   expired_mask, any_expired        valid && ready
// cfg       sink     index, data                      valid (ready held high)
//
// One item per cycle while result is not stalled; each item yields one result, shown in the cycle after its transfer.
// All checkpoint cells update in parallel; a tick decrements every armed cell with a nonzero count.
// The result sits in one output register; item.ready stays high while it is
// empty or being taken, so a stall on result holds item after one entry.
// Reset clears all armed flags and the result valid flag and loads the register reset values.

module checkpoint_deadline_watchdog_core #(
    parameter int unsigned NUM_CHECKPOINTS = 10,
    parameter int unsigned DEADLINE_WIDTH  = 12
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    cdw_item_if.sink        item,
    cdw_result_if.source    result,
    cdw_cfg_if.sink         cfg
);
    import cdw_pkg::*;

    logic [MASK_W-1:0]          start_mask;
    logic [MASK_W-1:0]          end_mask;
    logic [DL_REG_W-1:0]        deadlines_low;
    logic [DL_REG_W-1:0]        deadlines_high;

    logic                       accept;
    logic                       tick;
    logic                       in_range;
    logic [NUM_CHECKPOINTS-1:0] disarm;
    logic [NUM_CHECKPOINTS-1:0] expired;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [MASK_W-1:0]          mask_reg;
    logic [MASK_W-1:0]          mask_next;
    logic                       any_reg;
    logic                       any_next;

    cdw_cfg u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .start_mask     (start_mask),
        .end_mask       (end_mask),
        .deadlines_low  (deadlines_low),
        .deadlines_high (deadlines_high)
    );

    assign item.ready = ~out_valid_reg | result.ready;
    assign accept     = item.valid & item.ready;
    assign tick       = accept & item.func;
    assign in_range   = item.cp_index < CP_IDX_W'(NUM_CHECKPOINTS);

    for (genvar i = 0; i < NUM_CHECKPOINTS; i++)
    begin : g_cell
        localparam int unsigned SLOT = i % PER_REG;
        localparam int unsigned LSB  = SLOT * DEADLINE_WIDTH;

        cell_ctrl_t                ctrl;
        logic [DEADLINE_WIDTH-1:0] deadline;
        logic                      neighbor;

        assign ctrl.tick  = tick;
        assign ctrl.hit   = accept & ~item.func & in_range
                            & (item.cp_index == CP_IDX_W'(i));
        assign ctrl.start = start_mask[i];
        assign ctrl.stop  = end_mask[i];

        if (i < PER_REG)
        begin : g_low
            assign deadline = deadlines_low[LSB +: DEADLINE_WIDTH];
        end
        else
        begin : g_high
            assign deadline = deadlines_high[LSB +: DEADLINE_WIDTH];
        end

        if (i == NUM_CHECKPOINTS - 1)
        begin : g_last
            assign neighbor = 1'b0;
        end
        else
        begin : g_mid
            assign neighbor = disarm[i+1];
        end

        cdw_cell #(
            .DEADLINE_WIDTH (DEADLINE_WIDTH)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .deadline   (deadline),
            .disarm_in  (neighbor),
            .disarm_out (disarm[i]),
            .expired    (expired[i])
        );
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        mask_next      = mask_reg;
        any_next       = any_reg;
        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (accept)
        begin
            out_valid_next = 1'b1;
            mask_next      = MASK_W'(expired);
            any_next       = |expired;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mask_reg <= mask_next;
        any_reg  <= any_next;
    end

    assign result.valid        = out_valid_reg;
    assign result.expired_mask = mask_reg;
    assign result.any_expired  = any_reg;

endmodule

`default_nettype wire

// ===== tb/checkpoint_deadline_watchdog_core_tb.sv =====
`default_nettype none

module checkpoint_deadline_watchdog_core_tb;
    import cdw_pkg::*;

    localparam int NUM_CP = 10;
    localparam int DL_W = 12;
    localparam logic FUNC_EVENT = 1'b0;
    localparam logic FUNC_TICK = 1'b1;
    localparam int PHASES = 12;
    localparam int PHASE_ITEMS = 150;
    localparam int SETTLE_CYCLES = 3;

    typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic               func;
        logic [3:0]         idx;
        bit                 pinned;
        logic [MASK_W-1:0]  pin_mask;
        logic [MASK_W-1:0]  s_mask;
        logic [MASK_W-1:0]  e_mask;
        logic [DL_REG_W-1:0] lo;
        logic [DL_REG_W-1:0] hi;
    } stim_row_t;

    typedef struct {
        logic [MASK_W-1:0]  mask;
        logic               any;
    } expiry_t;

    logic clk;
    logic rst_n;

    cdw_item_if   item_ch();
    cdw_result_if res_ch();
    cdw_cfg_if    cfg_ch();

    checkpoint_deadline_watchdog_core uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    logic [MASK_W-1:0]   start_q;
    logic [MASK_W-1:0]   end_q;
    logic [DL_REG_W-1:0] dl_lo;
    logic [DL_REG_W-1:0] dl_hi;
    bit                  armed [NUM_CP];
    logic [DL_W-1:0]     remain [NUM_CP];

    expiry_t   expiry_q[$];
    stim_row_t stim_rows[$];
    int unsigned errors;
    bit          pin_on;
    logic [MASK_W-1:0] pin_mask;
    int src_mode;
    int src_count;
    int walk_cp;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [DL_W-1:0] deadline_of(input logic [3:0] cp);
        if (cp < 5)
            return dl_lo[cp*DL_W +: DL_W];
        else
            return dl_hi[(cp-5)*DL_W +: DL_W];
    endfunction

    function automatic logic [MASK_W-1:0] watchdog_advance(input logic f, input logic [3:0] cp);
        logic [MASK_W-1:0] fired;
        int i;
        fired = '0;
        if (f == FUNC_EVENT)
        begin
            if (cp < NUM_CP)
            begin
                if (end_q[cp])
                begin
                    if (cp != 0)
                        armed[cp-1] = 1'b0;
                end
                else
                begin
                    remain[cp] = deadline_of(cp);
                    armed[cp] = 1'b1;
                    if (!start_q[cp] && cp != 0)
                        armed[cp-1] = 1'b0;
                end
            end
        end
        else
        begin
            for (i = 0; i < NUM_CP; i++)
            begin
                if (armed[i] && remain[i] != 0)
                begin
                    remain[i] = remain[i] - 1'b1;
                    if (remain[i] == 0)
                    begin
                        fired[i] = 1'b1;
                        armed[i] = 1'b0;
                    end
                end
            end
        end
        return fired;
    endfunction

    function automatic logic [DL_REG_W-1:0] pack5(input int a, input int b, input int c,
                                                  input int d, input int e);
        return {e[DL_W-1:0], d[DL_W-1:0], c[DL_W-1:0], b[DL_W-1:0], a[DL_W-1:0]};
    endfunction

    function automatic logic [DL_REG_W-1:0] rand_deadlines();
        logic [DL_REG_W-1:0] v;
        int k;
        int r;
        for (k = 0; k < 5; k++)
        begin
            r = $urandom_range(0, 9);
            if (r < 7)
                v[k*DL_W +: DL_W] = DL_W'($urandom_range(0, 6));
            else if (r == 7)
                v[k*DL_W +: DL_W] = '0;
            else if (r == 8)
                v[k*DL_W +: DL_W] = '1;
            else
                v[k*DL_W +: DL_W] = DL_W'($urandom_range(0, 4095));
        end
        return v;
    endfunction

    function automatic int draw_gap(input int mode);
        if (mode == 0)
            return 0;
        else if (mode == 1)
            return $urandom_range(0, 18);
        else
            return $urandom_range(0, 3);
    endfunction

    task automatic report_mismatch(input string what, input logic [MASK_W-1:0] got,
                                   input logic [MASK_W-1:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        errors++;
    endtask

    task automatic add_item(input logic f, input logic [3:0] idx, input bit pin,
                            input logic [MASK_W-1:0] pmask);
        stim_row_t r;
        r = '{ROW_ITEM, f, idx, pin, pmask, '0, '0, '0, '0};
        stim_rows.push_back(r);
    endtask

    task automatic add_cfg(input logic [MASK_W-1:0] s, input logic [MASK_W-1:0] e,
                           input logic [DL_REG_W-1:0] lo, input logic [DL_REG_W-1:0] hi);
        stim_row_t r;
        r = '{ROW_CFG, FUNC_EVENT, 4'd0, 1'b0, '0, s, e, lo, hi};
        stim_rows.push_back(r);
    endtask

    task automatic send_item(input logic f, input logic [3:0] idx, input bit pin,
                             input logic [MASK_W-1:0] pmask);
        int gap;
        if (src_count % 50 == 0)
            src_mode = $urandom_range(0, 2);
        src_count++;
        gap = draw_gap(src_mode);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.func <= f;
        item_ch.cp_index <= idx;
        pin_on = pin;
        pin_mask = pmask;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // drop valid and wait for every pending transfer to come back
    task automatic settle();
        item_ch.valid <= 1'b0;
        @(negedge clk);
        while (expiry_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic apply_cfg(input logic [MASK_W-1:0] s, input logic [MASK_W-1:0] e,
                             input logic [DL_REG_W-1:0] lo, input logic [DL_REG_W-1:0] hi);
        cfg_reg_t regs [4];
        logic [DL_REG_W-1:0] vals [4];
        int k;
        regs = '{REG_START_MASK, REG_END_MASK, REG_DL_LOW, REG_DL_HIGH};
        vals = '{DL_REG_W'(s), DL_REG_W'(e), lo, hi};
        for (k = 0; k < 4; k++)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= regs[k];
            cfg_ch.data <= vals[k];
            @(posedge clk);
            while (!cfg_ch.ready)
                @(posedge clk);
            @(negedge clk);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin : monitor
        expiry_t e;
        logic [MASK_W-1:0] m;
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (expiry_q.size() == 0)
                    report_mismatch("result with nothing pending", res_ch.expired_mask, '0);
                else
                begin
                    e = expiry_q.pop_front();
                    if (res_ch.expired_mask !== e.mask)
                        report_mismatch("expired_mask", res_ch.expired_mask, e.mask);
                    if (res_ch.any_expired !== e.any)
                        report_mismatch("any_expired", MASK_W'(res_ch.any_expired),
                                        MASK_W'(e.any));
                end
            end
            if (item_ch.valid && item_ch.ready)
            begin
                m = watchdog_advance(item_ch.func, item_ch.cp_index);
                if (pin_on)
                    m = pin_mask;
                expiry_q.push_back('{m, |m});
            end
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.index)
                    REG_START_MASK: start_q = cfg_ch.data[MASK_W-1:0];
                    REG_END_MASK:   end_q = cfg_ch.data[MASK_W-1:0];
                    REG_DL_LOW:     dl_lo = cfg_ch.data;
                    REG_DL_HIGH:    dl_hi = cfg_ch.data;
                endcase
            end
        end
    end

    initial
    begin : drain
        int stall;
        int mode;
        int count;
        count = 0;
        mode = 0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (count % 40 == 0)
                mode = $urandom_range(0, 2);
            count++;
            stall = draw_gap(mode);
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
            while (!res_ch.valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin : stimulus
        stim_row_t row;
        int ph;
        int n;
        int r;
        logic [MASK_W-1:0] s;
        logic [MASK_W-1:0] e;
        logic [DL_REG_W-1:0] lo;
        logic [DL_REG_W-1:0] hi;
        logic [3:0] idx;

        clk = 1'b0;
        rst_n = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.func = FUNC_EVENT;
        item_ch.cp_index = '0;
        res_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_START_MASK;
        cfg_ch.data = '0;
        errors = 0;
        pin_on = 1'b0;
        pin_mask = '0;
        src_mode = 0;
        src_count = 0;
        walk_cp = 0;
        start_q = START_MASK_RST;
        end_q = END_MASK_RST;
        dl_lo = DL_LOW_RST;
        dl_hi = DL_HIGH_RST;
        for (n = 0; n < NUM_CP; n++)
        begin
            armed[n] = 1'b0;
            remain[n] = '0;
        end

        add_item(FUNC_TICK, 4'd0, 1'b1, '0);
        add_item(FUNC_EVENT, 4'd15, 1'b1, '0);
        add_item(FUNC_EVENT, 4'd10, 1'b1, '0);
        add_item(FUNC_EVENT, 4'd3, 1'b1, '0);
        add_cfg(10'h101, 10'h300, pack5(2, 1, 0, 3, 4095), pack5(1, 2, 1, 1, 0));
        add_item(FUNC_EVENT, 4'd0, 1'b1, '0);
        add_item(FUNC_EVENT, 4'd1, 1'b1, '0);
        add_item(FUNC_TICK, 4'd0, 1'b0, '0);
        add_item(FUNC_EVENT, 4'd2, 1'b1, '0);
        add_item(FUNC_EVENT, 4'd4, 1'b1, '0);
        add_item(FUNC_TICK, 4'd9, 1'b0, '0);
        add_item(FUNC_EVENT, 4'd5, 1'b1, '0);
        add_item(FUNC_EVENT, 4'd6, 1'b1, '0);
        add_item(FUNC_TICK, 4'd0, 1'b0, '0);
        add_item(FUNC_TICK, 4'd15, 1'b0, '0);
        add_item(FUNC_EVENT, 4'd8, 1'b1, '0);
        add_item(FUNC_EVENT, 4'd7, 1'b1, '0);
        add_item(FUNC_EVENT, 4'd9, 1'b1, '0);
        add_item(FUNC_TICK, 4'd0, 1'b0, '0);
        add_item(FUNC_EVENT, 4'd0, 1'b1, '0);
        add_item(FUNC_EVENT, 4'd3, 1'b1, '0);
        add_item(FUNC_TICK, 4'd0, 1'b0, '0);
        add_item(FUNC_TICK, 4'd0, 1'b0, '0);
        add_item(FUNC_TICK, 4'd0, 1'b0, '0);
        add_cfg(10'h3FF, 10'h000, '1, '1);
        add_item(FUNC_EVENT, 4'd9, 1'b1, '0);
        add_item(FUNC_TICK, 4'd0, 1'b0, '0);

        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (stim_rows[k])
        begin
            row = stim_rows[k];
            if (row.kind == ROW_CFG)
            begin
                settle();
                apply_cfg(row.s_mask, row.e_mask, row.lo, row.hi);
            end
            else
                send_item(row.func, row.idx, row.pinned, row.pin_mask);
        end

        for (ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    s = '0;
                    e = '0;
                    lo = rand_deadlines();
                    hi = rand_deadlines();
                end
                1:
                begin
                    s = '1;
                    e = '1;
                    lo = rand_deadlines();
                    hi = rand_deadlines();
                end
                2:
                begin
                    s = '1;
                    e = '0;
                    lo = '0;
                    hi = '0;
                end
                3:
                begin
                    s = START_MASK_RST;
                    e = END_MASK_RST;
                    lo = '1;
                    hi = '1;
                end
                default:
                begin
                    s = MASK_W'($urandom_range(0, 1023));
                    e = MASK_W'($urandom_range(0, 1023) & $urandom_range(0, 1023));
                    lo = rand_deadlines();
                    hi = rand_deadlines();
                end
            endcase
            settle();
            apply_cfg(s, e, lo, hi);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 40)
                    send_item(FUNC_TICK, 4'($urandom_range(0, 15)), 1'b0, '0);
                else
                begin
                    if (r < 85)
                    begin
                        walk_cp = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 9)
                                                              : (walk_cp + 1) % NUM_CP;
                        idx = 4'(walk_cp);
                    end
                    else if (r < 95)
                        idx = 4'($urandom_range(0, 9));
                    else
                        idx = 4'($urandom_range(10, 15));
                    send_item(FUNC_EVENT, idx, 1'b0, '0);
                end
            end
        end

        item_ch.valid <= 1'b0;
        while (expiry_q.size() != 0)
            @(negedge clk);
        repeat (5) @(negedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
